// ----- design/axr3_pkg.sv -----
// Shared types, widths and constants for the 3D axis rotation block.
// Holds the CORDIC arctangent table and the job word carried from front to back.
// No dependencies.
package axr3_pkg;

  // Field widths
  localparam int COMP_W  = 24;
  localparam int ANGLE_W = 16;

  // CORDIC datapath: Q1.30 values in 32-bit signed words
  localparam int CW      = 32;
  localparam int FRAC    = 30;
  localparam int STEPS   = 30;

  // Product and rounding widths
  localparam int PROD_W  = COMP_W + CW;
  localparam int RND_W   = PROD_W + 2;
  localparam int RES_W   = RND_W - FRAC;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [CW-1:0]     cq_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [RES_W-1:0]  res_t;

  // Axis selector codes
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Gain-compensated start value, round(K * 2^30)
  localparam cq_t CORDIC_K = 32'sd652032874;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam res_t  RES_MAX  = res_t'(COMP_MAX);
  localparam res_t  RES_MIN  = res_t'(COMP_MIN);
  localparam rnd_t  RND_HALF = rnd_t'(1) <<< (FRAC - 1);

  // Classified work word: the rotated pair (p, q), the axis component and the angle split
  typedef struct packed {
    axis_t       axis;
    logic        rot;
    comp_t       p;
    comp_t       q;
    comp_t       keep;
    logic [1:0]  quad;
    logic [29:0] resid;
  } job_t;

  // atan(2^-i) as a 32-bit fraction of a full turn
  function automatic cq_t atan_turn(input int unsigned i);
    cq_t v;
    case (i)
      0:       v = 32'sh20000000;
      1:       v = 32'sh12E4051E;
      2:       v = 32'sh09FB385B;
      3:       v = 32'sh051111D4;
      4:       v = 32'sh028B0D43;
      5:       v = 32'sh0145D7E1;
      6:       v = 32'sh00A2F61E;
      7:       v = 32'sh00517C55;
      8:       v = 32'sh0028BE53;
      9:       v = 32'sh00145F2F;
      10:      v = 32'sh000A2F98;
      11:      v = 32'sh000517CC;
      12:      v = 32'sh00028BE6;
      13:      v = 32'sh000145F3;
      14:      v = 32'sh0000A2FA;
      15:      v = 32'sh0000517D;
      16:      v = 32'sh000028BE;
      17:      v = 32'sh0000145F;
      18:      v = 32'sh00000A30;
      19:      v = 32'sh00000518;
      20:      v = 32'sh0000028C;
      21:      v = 32'sh00000146;
      22:      v = 32'sh000000A3;
      23:      v = 32'sh00000051;
      24:      v = 32'sh00000029;
      25:      v = 32'sh00000014;
      26:      v = 32'sh0000000A;
      27:      v = 32'sh00000005;
      28:      v = 32'sh00000003;
      29:      v = 32'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/axr3_if.sv -----
// Valid/ready channel interfaces for the rotation block: request words and result words.
// Depends on axr3_pkg for field widths.
interface axr3_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic signed [axr3_pkg::COMP_W-1:0] vx;
  logic signed [axr3_pkg::COMP_W-1:0] vy;
  logic signed [axr3_pkg::COMP_W-1:0] vz;
  logic [axr3_pkg::ANGLE_W-1:0]       angle;

  modport source (output valid, cmd, vx, vy, vz, angle, input ready);
  modport sink   (input valid, cmd, vx, vy, vz, angle, output ready);
endinterface

interface axr3_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [axr3_pkg::COMP_W-1:0] rx;
  logic signed [axr3_pkg::COMP_W-1:0] ry;
  logic signed [axr3_pkg::COMP_W-1:0] rz;

  modport source (output valid, rx, ry, rz, input ready);
  modport sink   (input valid, rx, ry, rz, output ready);
endinterface

// ----- design/axr3_front.sv -----
// Front end: accepts request words and sorts each into a rotation job.
// Depends on axr3_pkg and axr3_in_if.
module axr3_front (
  axr3_in_if.sink          item,
  input  logic             full,
  output logic             push,
  output axr3_pkg::job_t   job
);

  axr3_pkg::axis_t axis;
  logic [31:0]     turn;

  // Take a word whenever the queue has room
  assign item.ready = !full;
  assign push       = item.valid && !full;

  // Left-align the angle to a 32-bit turn fraction
  assign turn = 32'(item.angle) << (32 - axr3_pkg::ANGLE_W);
  assign axis = axr3_pkg::axis_t'(item.cmd);

  // Pick the rotated pair and the component along the axis
  always_comb begin
    job.axis  = axis;
    job.rot   = (axis != axr3_pkg::AXIS_NONE);
    job.quad  = turn[31:30];
    job.resid = turn[29:0];
    unique case (axis) inside
      axr3_pkg::AXIS_X: begin
        job.p    = item.vy;
        job.q    = item.vz;
        job.keep = item.vx;
      end
      axr3_pkg::AXIS_Y: begin
        job.p    = item.vz;
        job.q    = item.vx;
        job.keep = item.vy;
      end
      axr3_pkg::AXIS_Z, axr3_pkg::AXIS_NONE: begin
        job.p    = item.vx;
        job.q    = item.vy;
        job.keep = item.vz;
      end
      default: begin
        job.p    = item.vx;
        job.q    = item.vy;
        job.keep = item.vz;
      end
    endcase
  end

endmodule

// ----- design/axr3_queue.sv -----
// Short job queue between the front end and the CORDIC back end.
// Depends on axr3_pkg.
module axr3_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  axr3_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output axr3_pkg::job_t head_job
);

  axr3_pkg::job_t                  slots [0:axr3_pkg::QDEPTH-1];
  logic [axr3_pkg::QAW-1:0]        wr_ptr;
  logic [axr3_pkg::QAW-1:0]        rd_ptr;
  logic [axr3_pkg::QCNT_W-1:0]     count;

  assign full     = (count == axr3_pkg::QCNT_W'(axr3_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head_job = slots[rd_ptr];

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == axr3_pkg::QAW'(axr3_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == axr3_pkg::QAW'(axr3_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + axr3_pkg::QCNT_W'(push) - axr3_pkg::QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= axr3_pkg::QCNT_W'(axr3_pkg::QDEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + axr3_pkg::QCNT_W'($past(push))
                      - axr3_pkg::QCNT_W'($past(pop)))
    else $error("queue count out of step with push and pop");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

// ----- design/axr3_cordic.sv -----
// Pipelined rotation-mode CORDIC: one registered stage per iteration, shared stall.
// Depends on axr3_pkg.
module axr3_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  axr3_pkg::job_t in_job,
  output logic           out_valid,
  output axr3_pkg::job_t out_job,
  output axr3_pkg::cq_t  out_x,
  output axr3_pkg::cq_t  out_y
);

  logic           vld [0:axr3_pkg::STEPS];
  axr3_pkg::job_t job [0:axr3_pkg::STEPS];
  axr3_pkg::cq_t  x   [0:axr3_pkg::STEPS];
  axr3_pkg::cq_t  y   [0:axr3_pkg::STEPS];
  axr3_pkg::cq_t  z   [0:axr3_pkg::STEPS];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= axr3_pkg::STEPS; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 0; k < axr3_pkg::STEPS; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // Load the start vector, then one micro-rotation per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      job[0] <= in_job;
      x[0]   <= axr3_pkg::CORDIC_K;
      y[0]   <= '0;
      z[0]   <= axr3_pkg::cq_t'({2'b00, in_job.resid});
      for (int k = 0; k < axr3_pkg::STEPS; k++) begin
        job[k+1] <= job[k];
        if (!z[k][axr3_pkg::CW-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - axr3_pkg::atan_turn(k);
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + axr3_pkg::atan_turn(k);
        end
      end
    end
  end

  assign out_valid = vld[axr3_pkg::STEPS];
  assign out_job   = job[axr3_pkg::STEPS];
  assign out_x     = x[axr3_pkg::STEPS];
  assign out_y     = y[axr3_pkg::STEPS];

endmodule

// ----- design/axr3_mac.sv -----
// Back end tail: quadrant fold, products, round and saturate, output register.
// Depends on axr3_pkg and axr3_out_if; drives the shared stall for the back end.
module axr3_mac (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  axr3_pkg::job_t in_job,
  input  axr3_pkg::cq_t  in_x,
  input  axr3_pkg::cq_t  in_y,
  output logic           adv,
  axr3_out_if.source     result
);

  logic            cs_v;
  axr3_pkg::job_t  cs_job;
  axr3_pkg::cq_t   cs_c;
  axr3_pkg::cq_t   cs_s;

  logic            prod_v;
  axr3_pkg::job_t  prod_job;
  axr3_pkg::prod_t pc;
  axr3_pkg::prod_t qs;
  axr3_pkg::prod_t qc;
  axr3_pkg::prod_t ps;

  logic            out_v;
  axr3_pkg::comp_t rp;
  axr3_pkg::comp_t rq;

  // round((a +/- b) / 2^30), ties up, then clamp to the component range
  function automatic axr3_pkg::comp_t round_sat(input axr3_pkg::prod_t a,
                                                input axr3_pkg::prod_t b,
                                                input logic            neg);
    axr3_pkg::rnd_t t;
    axr3_pkg::res_t r;
    axr3_pkg::comp_t o;
    t = neg ? (axr3_pkg::rnd_t'(a) - axr3_pkg::rnd_t'(b))
            : (axr3_pkg::rnd_t'(a) + axr3_pkg::rnd_t'(b));
    t = t + axr3_pkg::RND_HALF;
    r = axr3_pkg::res_t'(t >>> axr3_pkg::FRAC);
    if (r > axr3_pkg::RES_MAX) begin
      o = axr3_pkg::COMP_MAX;
    end else if (r < axr3_pkg::RES_MIN) begin
      o = axr3_pkg::COMP_MIN;
    end else begin
      o = axr3_pkg::comp_t'(r);
    end
    return o;
  endfunction

  // Hold the whole back end while a result waits
  assign adv = !out_v || result.ready;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_v   <= 1'b0;
      prod_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (adv) begin
      cs_v   <= in_valid;
      prod_v <= cs_v;
      out_v  <= prod_v;
    end
  end

  // Fold the quadrant into cos and sin
  always_ff @(posedge clk) begin
    if (adv) begin
      cs_job <= in_job;
      unique case (in_job.quad)
        2'd0: begin
          cs_c <= in_x;
          cs_s <= in_y;
        end
        2'd1: begin
          cs_c <= -in_y;
          cs_s <= in_x;
        end
        2'd2: begin
          cs_c <= -in_x;
          cs_s <= -in_y;
        end
        default: begin
          cs_c <= in_y;
          cs_s <= -in_x;
        end
      endcase
    end
  end

  // Form the four exact products
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_job <= cs_job;
      pc       <= cs_job.p * cs_c;
      qs       <= cs_job.q * cs_s;
      qc       <= cs_job.q * cs_c;
      ps       <= cs_job.p * cs_s;
    end
  end

  // Round the rotated pair, or pass it through for the unused axis code
  assign rp = prod_job.rot ? round_sat(pc, qs, 1'b0) : prod_job.p;
  assign rq = prod_job.rot ? round_sat(qc, ps, 1'b1) : prod_job.q;

  // Route the pair back to x, y, z
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (prod_job.axis) inside
        axr3_pkg::AXIS_X: begin
          result.rx <= prod_job.keep;
          result.ry <= rp;
          result.rz <= rq;
        end
        axr3_pkg::AXIS_Y: begin
          result.rx <= rq;
          result.ry <= prod_job.keep;
          result.rz <= rp;
        end
        axr3_pkg::AXIS_Z, axr3_pkg::AXIS_NONE: begin
          result.rx <= rp;
          result.ry <= rq;
          result.rz <= prod_job.keep;
        end
        default: begin
          result.rx <= rp;
          result.ry <= rq;
          result.rz <= prod_job.keep;
        end
      endcase
    end
  end

  assign result.valid = out_v;

  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    prod_v && !adv |=> prod_v)
    else $error("product stage dropped a word during a stall");

  a_cs_hold: assert property (@(posedge clk) disable iff (rst)
    cs_v && !adv |=> cs_v && $stable(cs_c) && $stable(cs_s))
    else $error("cos/sin stage changed during a stall");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !adv |-> out_v)
    else $error("back end stalled with an empty output register");

endmodule

// ----- design/axis_rotation_3d.sv -----
// Rotation of a 3D vector about the X, Y or Z axis by a binary turn angle.
//
// Channels: item (sink) carries cmd, vx, vy, vz, angle; result (source)
// carries rx, ry, rz. A word moves at a rising clk edge with valid and ready high.
// cmd selects the axis (0 X, 1 Y, 2 Z); code 3 returns the vector unchanged.
// angle is angle/2^16 of a full turn; components are signed 24-bit words.
//
// Throughput: one word per cycle, sustained, as long as result is taken.
// Path from acceptance to result valid: the job is stored in the front
// queue and enters the CORDIC load stage, passes 30 iteration stages,
// then quadrant fold, products and the round/saturate output register.
// A 4-deep queue decouples the front from the back pipeline: when result
// stalls, the back pipeline holds in place and item keeps being accepted
// until the queue fills, then item.ready drops.
// Reset (rst, synchronous, active high) empties the queue and clears every
// pipeline valid bit; no result is lost or repeated across stalls.
// Depends on axr3_pkg, axr3_if and the axr3_* submodules.
module axis_rotation_3d (
  input  logic       clk,
  input  logic       rst,
  axr3_in_if.sink    item,
  axr3_out_if.source result
);

  logic           push;
  logic           full;
  axr3_pkg::job_t push_job;
  logic           nonempty;
  axr3_pkg::job_t head_job;
  logic           adv;
  logic           pop;
  logic           cd_valid;
  axr3_pkg::job_t cd_job;
  axr3_pkg::cq_t  cd_x;
  axr3_pkg::cq_t  cd_y;

  // Feed the back pipeline whenever it moves and a job waits
  assign pop = adv && nonempty;

  axr3_front u_front (
    .item (item),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  axr3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head_job (head_job)
  );

  axr3_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (nonempty),
    .in_job    (head_job),
    .out_valid (cd_valid),
    .out_job   (cd_job),
    .out_x     (cd_x),
    .out_y     (cd_y)
  );

  axr3_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cd_valid),
    .in_job   (cd_job),
    .in_x     (cd_x),
    .in_y     (cd_y),
    .adv      (adv),
    .result   (result)
  );

endmodule
